### hw/rtl/dcws_pkg.sv
// Shared constants and controller/datapath interface types for the daily case statistics unit.
package dcws_pkg;

    localparam int WIN_LEN     = 7;       // samples in the averaging window
    localparam int SAMPLE_W    = 24;      // bits of one daily count
    localparam int SUM_W       = 27;      // window sum incl. newest sample
    localparam int FILL_W      = 3;       // holds 0 .. WIN_LEN-1
    localparam int TOTAL_W     = 32;      // saturating cumulative total
    localparam int POP_W       = 33;      // population register
    localparam int POP_RESET   = 100000;
    localparam int RATE_SCALE  = 100000;  // per 100k people
    localparam int FRAC_W      = 8;       // fractional bits of the results
    localparam int PROD_W      = 49;      // total * RATE_SCALE
    localparam int QUO_W       = 57;      // dividend / quotient width of the rate divider
    localparam int AVG_W       = 32;
    localparam int AVG_Q_W     = 24;      // floor(window sum / WIN_LEN)
    localparam int AVG_REM_W   = 3;       // remainder of a divide by WIN_LEN
    localparam int AVG_RECIP   = 153391690; // ceil(2^AVG_SHIFT / WIN_LEN)
    localparam int AVG_SHIFT   = 30;      // exact for sums below 2^27
    localparam int AVG_PROD_W  = 55;      // SUM_W + 28-bit reciprocal
    localparam int DIV_STEPS   = 57;      // one quotient bit per cycle
    localparam int CNT_W       = 6;
    localparam int IN_DATA_W   = 24;
    localparam int OUT_DATA_W  = 128;

    // Controller -> datapath
    typedef struct packed {
        logic accept;   // input beat taken this cycle
        logic load;     // form products, load the divider
        logic step;     // one divider iteration
        logic store;    // move quotients into the output register
    } t_cmd;

    // Datapath -> controller
    typedef struct packed {
        logic out_free; // output register empty or drained this cycle
    } t_status;

endpackage

### hw/rtl/dcws_ctrl.sv
// Sequencing state machine for the daily case statistics unit.
module dcws_ctrl import dcws_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_MUL  = 4'b0010,
        S_DIV  = 4'b0100,
        S_DONE = 4'b1000
    } t_state;

    t_state             r_state, n_state;
    logic [CNT_W-1:0]   r_cnt, n_cnt;

    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        o_cmd       = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = S_MUL;
                end
            end
            S_MUL: begin
                o_cmd.load = 1'b1;
                n_cnt      = '0;
                n_state    = S_DIV;
            end
            S_DIV: begin
                o_cmd.step = 1'b1;
                n_cnt      = r_cnt + 1'b1;
                if (r_cnt == CNT_W'(DIV_STEPS - 1)) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (i_status.out_free) begin
                    o_cmd.store = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

endmodule

### hw/rtl/dcws_dp.sv
// Datapath: window and total state, rate multiplier, reciprocal mean, bit-serial divider, output register.
module dcws_dp import dcws_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_cmd                i_cmd,
    output t_status             o_status,
    input  logic                i_first_day,
    input  logic [SAMPLE_W-1:0] i_day_cases,
    input  logic                i_cfg_wr,
    input  logic [POP_W-1:0]    i_cfg_data,
    input  logic                i_out_ready,
    output logic                o_out_valid,
    output logic                o_avg_valid,
    output logic [AVG_W-1:0]    o_window_avg,
    output logic [TOTAL_W-1:0]  o_cum_total,
    output logic [QUO_W-1:0]    o_cum_per_100k
);

    // series state
    logic [SAMPLE_W-1:0] r_samp [WIN_LEN-1];
    logic [SUM_W-1:0]    r_sum;
    logic [FILL_W-1:0]   r_fill;
    logic [TOTAL_W-1:0]  r_total;
    logic [POP_W-1:0]    r_pop;

    // per-item working registers
    logic [SUM_W-1:0]     r_full;
    logic                 r_avg_ok;
    logic [AVG_Q_W-1:0]   r_avg_q;
    logic [QUO_W-1:0]     r_rate_q;
    logic [POP_W-1:0]     r_rate_rem;

    // output register
    logic                r_out_valid;
    logic                r_out_avg_ok;
    logic [AVG_W-1:0]    r_out_avg;
    logic [TOTAL_W-1:0]  r_out_total;
    logic [QUO_W-1:0]    r_out_rate;

    logic [SUM_W-1:0]      w_base_sum, w_full, w_new_sum;
    logic [FILL_W-1:0]     w_base_fill;
    logic [SAMPLE_W-1:0]   w_oldest;
    logic [TOTAL_W-1:0]    w_base_total;
    logic [TOTAL_W:0]      w_total_sum;
    logic                  w_valid;
    logic [PROD_W-1:0]     w_prod;
    logic [POP_W-1:0]      w_pop_eff;
    logic [AVG_PROD_W-1:0] w_avg_prod;
    logic [AVG_REM_W-1:0]  w_avg_rem;
    logic [FRAC_W-1:0]     w_avg_frac;
    logic [POP_W:0]        w_rate_sh, w_rate_diff;
    logic                  w_rate_ge;

    // first_day restarts the series before this sample
    assign w_base_sum   = i_first_day ? '0 : r_sum;
    assign w_base_fill  = i_first_day ? '0 : r_fill;
    assign w_oldest     = i_first_day ? '0 : r_samp[WIN_LEN-2];
    assign w_base_total = i_first_day ? '0 : r_total;

    assign w_full      = w_base_sum + SUM_W'(i_day_cases);
    assign w_new_sum   = w_full - SUM_W'(w_oldest);
    assign w_valid     = (w_base_fill >= FILL_W'(WIN_LEN - 1));
    assign w_total_sum = {1'b0, w_base_total} + (TOTAL_W+1)'(i_day_cases);

    assign w_prod    = PROD_W'(r_total) * PROD_W'(RATE_SCALE);
    assign w_pop_eff = (r_pop == '0) ? POP_W'(1) : r_pop;

    // mean: integer part by reciprocal multiply, fraction from the remainder
    assign w_avg_prod = AVG_PROD_W'(r_full) * AVG_PROD_W'(AVG_RECIP);
    // full = 7q + r, so r = (full + q) mod 8
    assign w_avg_rem  = r_full[AVG_REM_W-1:0] + r_avg_q[AVG_REM_W-1:0];

    // floor(r * 256 / 7)
    always_comb begin
        case (w_avg_rem)
            3'd1:    w_avg_frac = 8'd36;
            3'd2:    w_avg_frac = 8'd73;
            3'd3:    w_avg_frac = 8'd109;
            3'd4:    w_avg_frac = 8'd146;
            3'd5:    w_avg_frac = 8'd182;
            3'd6:    w_avg_frac = 8'd219;
            default: w_avg_frac = 8'd0;
        endcase
    end

    // restoring divide step
    assign w_rate_sh   = {r_rate_rem, r_rate_q[QUO_W-1]};
    assign w_rate_diff = w_rate_sh - {1'b0, w_pop_eff};
    assign w_rate_ge   = (w_rate_sh >= {1'b0, w_pop_eff});

    assign o_status.out_free = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < WIN_LEN - 1; i++) begin
                r_samp[i] <= '0;
            end
            r_sum   <= '0;
            r_fill  <= '0;
            r_total <= '0;
            r_pop   <= POP_W'(POP_RESET);
        end else begin
            if (i_cfg_wr) begin
                r_pop <= i_cfg_data;
            end
            if (i_cmd.accept) begin
                r_samp[0] <= i_day_cases;
                for (int i = 1; i < WIN_LEN - 1; i++) begin
                    r_samp[i] <= i_first_day ? '0 : r_samp[i-1];
                end
                r_sum  <= w_new_sum;
                r_fill <= w_valid ? w_base_fill : w_base_fill + 1'b1;
                r_total <= w_total_sum[TOTAL_W] ? '1 : w_total_sum[TOTAL_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_full   <= w_full;
            r_avg_ok <= w_valid;
        end
        if (i_cmd.load) begin
            r_avg_q    <= w_avg_prod[AVG_SHIFT +: AVG_Q_W];
            r_rate_q   <= {w_prod, FRAC_W'(0)};
            r_rate_rem <= '0;
        end else if (i_cmd.step) begin
            if (w_rate_ge) begin
                r_rate_rem <= w_rate_diff[POP_W-1:0];
                r_rate_q   <= {r_rate_q[QUO_W-2:0], 1'b1};
            end else begin
                r_rate_rem <= w_rate_sh[POP_W-1:0];
                r_rate_q   <= {r_rate_q[QUO_W-2:0], 1'b0};
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.store) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.store) begin
            r_out_avg_ok <= r_avg_ok;
            r_out_avg    <= r_avg_ok ? {r_avg_q, w_avg_frac} : '0;
            r_out_total  <= r_total;
            r_out_rate   <= r_rate_q;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_avg_valid    = r_out_avg_ok;
    assign o_window_avg   = r_out_avg;
    assign o_cum_total    = r_out_total;
    assign o_cum_per_100k = r_out_rate;

endmodule

### hw/rtl/daily_case_window_statistics_unit.sv
// Top level of the daily case window statistics unit.
//
// Slave stream: one beat per day. tdata[23:0] is the case count; tuser set
//   starts a new series (window, fill count and total cleared first).
// Master stream: one beat per input beat, in order. tdata holds the seven
//   day mean and the total per 100000 people (both 8 fractional bits) and the
//   saturating cumulative total; tuser is 1 once seven samples are in the
//   window, the mean reads 0 before that.
// Config channel: 33-bit population, always ready; the user must write it
//   only while no beat is in flight (the block does not enforce this); zero is used as 1.
// Sequence from input beat to the output register: a load step forms the
//   constant product and the mean (reciprocal multiply) and loads the divider,
//   the bit-serial divide by the population follows, one quotient bit per
//   cycle, then the store. The next input beat is taken only after the
//   store, in the cycle after it.
// Stall: the next beat is taken even while the result waits at the receiver;
//   work stops at the store only if the previous result has not drained.
// Reset: synchronous, active low; series state cleared, population 100000.
module daily_case_window_statistics_unit import dcws_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // slave stream
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,   // [23:0] day_cases
    input  logic                  s_axis_tuser,   // [0] first_day
    // master stream
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0] m_axis_tdata,   // [31:0] window_avg, [63:32] cum_total,
                                                  // [120:64] cum_per_100k, [127:121] zero
    output logic                  m_axis_tuser,   // [0] avg_valid
    // configuration
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [POP_W-1:0]      i_cfg_data      // population
);

    t_cmd                w_cmd;
    t_status             w_status;
    logic [AVG_W-1:0]    w_avg;
    logic [TOTAL_W-1:0]  w_total;
    logic [QUO_W-1:0]    w_rate;

    // population register accepts a write every cycle
    assign o_cfg_ready = 1'b1;

    dcws_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    dcws_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .o_status       (w_status),
        .i_first_day    (s_axis_tuser),
        .i_day_cases    (s_axis_tdata[SAMPLE_W-1:0]),
        .i_cfg_wr       (i_cfg_valid),
        .i_cfg_data     (i_cfg_data),
        .i_out_ready    (m_axis_tready),
        .o_out_valid    (m_axis_tvalid),
        .o_avg_valid    (m_axis_tuser),
        .o_window_avg   (w_avg),
        .o_cum_total    (w_total),
        .o_cum_per_100k (w_rate)
    );

    // pack result fields, lowest first, zero fill to whole bytes
    assign m_axis_tdata = {(OUT_DATA_W - QUO_W - TOTAL_W - AVG_W)'(0), w_rate, w_total, w_avg};

endmodule
